// ===== design/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== design/mpba_pkg.sv =====
`default_nettype none

package mpba_pkg;

  localparam int SLOT_W    = 16;
  localparam int NUM_SLOTS = 4;
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 64;

  localparam logic [15:0] MARGIN_USE_POOL = 16'hFFFF;

  // result status codes
  localparam logic [2:0] ST_ALLOC    = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_MARGIN   = 3'd2;
  localparam logic [2:0] ST_FREED    = 3'd3;
  localparam logic [2:0] ST_BADTAG   = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  // register indexes
  localparam logic [1:0] REG_POOLS   = 2'd0;
  localparam logic [1:0] REG_SIZES   = 2'd1;
  localparam logic [1:0] REG_COUNTS  = 2'd2;
  localparam logic [1:0] REG_MARGINS = 2'd3;

  // how a request is finished
  localparam logic [2:0] FIN_NOFIT  = 3'd0;
  localparam logic [2:0] FIN_REJECT = 3'd1;
  localparam logic [2:0] FIN_GRANT  = 3'd2;
  localparam logic [2:0] FIN_MARGIN = 3'd3;
  localparam logic [2:0] FIN_FREE   = 3'd4;

  typedef struct packed {
    logic [2:0]  pools_in_use;
    logic [63:0] sizes;
    logic [63:0] counts;
    logic [63:0] margins;
    logic        reload;
  } cfg_t;

  typedef struct packed {
    logic       cap;
    logic       start;
    logic       next;
    logic       fin;
    logic [2:0] fin_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic fit_found;
    logic tag_ok;
    logic grant_ok;
    logic scan_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/mpba_regs.sv =====
`default_nettype none

module mpba_regs (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [mpba_pkg::CFG_AW-1:0]  paddr,
  input  wire  [mpba_pkg::CFG_DW-1:0]  pwdata,
  output logic [mpba_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready,
  output mpba_pkg::cfg_t               cfg
);
  import mpba_pkg::*;

  logic [2:0]  pools_r;
  logic [63:0] sizes_r;
  logic [63:0] counts_r;
  logic [63:0] margins_r;
  logic        reload_r;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[CFG_AW-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pools_r   <= '0;
      sizes_r   <= '0;
      counts_r  <= '0;
      margins_r <= '0;
      reload_r  <= 1'b0;
    end else begin
      reload_r <= 1'b0;
      if (wr) begin
        case (idx)
          REG_POOLS:   pools_r <= pwdata[2:0];
          REG_SIZES:   sizes_r <= pwdata;
          REG_COUNTS: begin
            counts_r <= pwdata;
            reload_r <= 1'b1;
          end
          REG_MARGINS: margins_r <= pwdata;
          default:     pools_r <= pools_r;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_POOLS:   prdata = {61'd0, pools_r};
      REG_SIZES:   prdata = sizes_r;
      REG_COUNTS:  prdata = counts_r;
      REG_MARGINS: prdata = margins_r;
      default:     prdata = '0;
    endcase
  end

  assign cfg.pools_in_use = pools_r;
  assign cfg.sizes        = sizes_r;
  assign cfg.counts       = counts_r;
  assign cfg.margins      = margins_r;
  assign cfg.reload       = reload_r;

endmodule

`default_nettype wire

// ===== design/mpba_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module mpba_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  mpba_pkg::dp_stat_t   stat,
  output mpba_pkg::dp_cmd_t    cmd
);
  import mpba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIT  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.fin_kind = FIN_NOFIT;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_FIT;
        end
      end
      S_FIT: begin
        // free with a valid tag and a fitting alloc both go on to the pool scan
        if (stat.is_free) begin
          if (stat.tag_ok) begin
            cmd.start = 1'b1;
            state_nxt = S_SCAN;
          end else if (slot_free) begin
            cmd.fin      = 1'b1;
            cmd.fin_kind = FIN_REJECT;
            state_nxt    = S_IDLE;
          end
        end else if (stat.fit_found) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end else if (slot_free) begin
          cmd.fin      = 1'b1;
          cmd.fin_kind = FIN_NOFIT;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.is_free) begin
          if (slot_free) begin
            cmd.fin      = 1'b1;
            cmd.fin_kind = FIN_FREE;
            state_nxt    = S_IDLE;
          end
        end else if (stat.grant_ok) begin
          if (slot_free) begin
            cmd.fin      = 1'b1;
            cmd.fin_kind = FIN_GRANT;
            state_nxt    = S_IDLE;
          end
        end else if (stat.scan_last) begin
          if (slot_free) begin
            cmd.fin      = 1'b1;
            cmd.fin_kind = FIN_MARGIN;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.next = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_NEXT(a_fin_shows, clk, rst_n, cmd.fin, out_valid_r)
  `ASSERT_IMPLIES(a_scan_free_tag, clk, rst_n, state_r == S_SCAN && stat.is_free, stat.tag_ok)
  `ASSERT_NEXT(a_cap_fit, clk, rst_n, cmd.cap, state_r == S_FIT)

endmodule

`default_nettype wire

// ===== design/mpba_dp.sv =====
`default_nettype none
`include "assert_macros.svh"

module mpba_dp #(
  parameter int POOL_COUNT = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  input  mpba_pkg::cfg_t     cfg,
  input  mpba_pkg::dp_cmd_t  cmd,
  output mpba_pkg::dp_stat_t stat,
  input  wire                in_action,
  input  wire  [15:0]        in_event_size,
  input  wire  [15:0]        in_margin_override,
  input  wire  [2:0]         in_free_tag,
  output logic               out_granted,
  output logic [2:0]         out_pool_tag,
  output logic [2:0]         out_status,
  output logic               out_fell_back,
  output logic [15:0]        out_free_after,
  output logic [15:0]        out_low_mark,
  output logic [31:0]        out_alloc_total,
  output logic [31:0]        out_fail_total,
  output logic [31:0]        out_fallback_total
);
  import mpba_pkg::*;

  localparam int PW      = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int ACT_MAX = (POOL_COUNT < NUM_SLOTS) ? POOL_COUNT : NUM_SLOTS;

  logic [15:0] size_a [POOL_COUNT];
  logic [15:0] cnt_a  [POOL_COUNT];
  logic [15:0] mrg_a  [POOL_COUNT];

  // pools above the packed slots see zero size, count and margin
  for (genvar g = 0; g < POOL_COUNT; g++) begin : g_slot
    if (g < NUM_SLOTS) begin : g_used
      assign size_a[g] = cfg.sizes[SLOT_W*g +: SLOT_W];
      assign cnt_a[g]  = cfg.counts[SLOT_W*g +: SLOT_W];
      assign mrg_a[g]  = cfg.margins[SLOT_W*g +: SLOT_W];
    end else begin : g_none
      assign size_a[g] = '0;
      assign cnt_a[g]  = '0;
      assign mrg_a[g]  = '0;
    end
  end

  logic [15:0] fc_r [POOL_COUNT];
  logic [15:0] lw_r [POOL_COUNT];
  logic [31:0] alloc_cnt_r, fail_cnt_r, fb_cnt_r;
  logic [31:0] alloc_nxt, fail_nxt, fb_nxt;

  logic        req_free_r;
  logic [15:0] req_size_r;
  logic [15:0] req_ovr_r;
  logic [2:0]  req_tag_r;
  logic [PW-1:0] cur_r, best_r;
  logic [15:0] snap_fc_r, snap_lw_r;

  logic [2:0]  n_act;
  logic        found;
  logic [PW-1:0] best;
  logic [15:0] best_sz;
  logic [15:0] fc_cur, lw_cur, fc_dec, lw_new, margin;
  logic        overflow;

  logic        res_granted, res_fb;
  logic [2:0]  res_tag, res_status;
  logic [15:0] res_fa, res_mf;

  assign n_act = (cfg.pools_in_use > 3'(ACT_MAX)) ? 3'(ACT_MAX) : cfg.pools_in_use;

  // best fit: smallest block size that holds the request, lowest index on ties
  always_comb begin
    found   = 1'b0;
    best    = '0;
    best_sz = '0;
    for (int p = 0; p < POOL_COUNT; p++) begin
      if (3'(p) < n_act && size_a[p] >= req_size_r && (!found || size_a[p] < best_sz)) begin
        found   = 1'b1;
        best    = PW'(p);
        best_sz = size_a[p];
      end
    end
  end

  assign fc_cur   = fc_r[cur_r];
  assign lw_cur   = lw_r[cur_r];
  assign fc_dec   = fc_cur - 16'd1;
  assign lw_new   = (fc_dec < lw_cur) ? fc_dec : lw_cur;
  assign margin   = (req_ovr_r != MARGIN_USE_POOL) ? req_ovr_r : mrg_a[cur_r];
  assign overflow = fc_cur >= cnt_a[cur_r];

  assign stat.is_free   = req_free_r;
  assign stat.fit_found = found;
  assign stat.tag_ok    = (req_tag_r != 3'd0) && (req_tag_r <= n_act);
  assign stat.grant_ok  = fc_cur > margin;
  assign stat.scan_last = (4'(cur_r) + 4'd1) >= {1'b0, n_act};

  always_comb begin
    res_granted = 1'b0;
    res_fb      = 1'b0;
    res_tag     = 3'd0;
    res_status  = ST_NOFIT;
    res_fa      = '0;
    res_mf      = '0;
    alloc_nxt   = alloc_cnt_r;
    fail_nxt    = fail_cnt_r;
    fb_nxt      = fb_cnt_r;
    case (cmd.fin_kind)
      FIN_NOFIT: res_status = ST_NOFIT;
      FIN_REJECT: res_status = (req_tag_r == 3'd0) ? ST_IGNORED : ST_BADTAG;
      FIN_GRANT: begin
        res_granted = 1'b1;
        res_fb      = (cur_r != best_r);
        res_tag     = 3'(cur_r) + 3'd1;
        res_status  = ST_ALLOC;
        res_fa      = fc_dec;
        res_mf      = lw_new;
        alloc_nxt   = alloc_cnt_r + 32'd1;
        if (cur_r != best_r) begin
          fb_nxt = fb_cnt_r + 32'd1;
        end
      end
      FIN_MARGIN: begin
        res_tag    = 3'(best_r) + 3'd1;
        res_status = ST_MARGIN;
        res_fa     = (cur_r == best_r) ? fc_cur : snap_fc_r;
        res_mf     = (cur_r == best_r) ? lw_cur : snap_lw_r;
        fail_nxt   = fail_cnt_r + 32'd1;
      end
      FIN_FREE: begin
        res_tag    = 3'(cur_r) + 3'd1;
        res_status = overflow ? ST_OVERFLOW : ST_FREED;
        res_fa     = overflow ? fc_cur : fc_cur + 16'd1;
        res_mf     = lw_cur;
      end
      default: res_status = ST_NOFIT;
    endcase
  end

  // request capture, scan pointer and best-pool snapshot
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_free_r <= in_action;
      req_size_r <= in_event_size;
      req_ovr_r  <= in_margin_override;
      req_tag_r  <= in_free_tag;
    end
    if (cmd.start) begin
      cur_r  <= req_free_r ? PW'(req_tag_r - 3'd1) : best;
      best_r <= best;
    end else if (cmd.next) begin
      cur_r <= cur_r + PW'(1);
    end
    if (cur_r == best_r) begin
      snap_fc_r <= fc_cur;
      snap_lw_r <= lw_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POOL_COUNT; i++) begin
        fc_r[i] <= '0;
        lw_r[i] <= '0;
      end
      alloc_cnt_r <= '0;
      fail_cnt_r  <= '0;
      fb_cnt_r    <= '0;
    end else begin
      if (cfg.reload) begin
        for (int i = 0; i < POOL_COUNT; i++) begin
          fc_r[i] <= cnt_a[i];
          lw_r[i] <= cnt_a[i];
        end
      end else if (cmd.fin && cmd.fin_kind == FIN_GRANT) begin
        fc_r[cur_r] <= fc_dec;
        lw_r[cur_r] <= lw_new;
      end else if (cmd.fin && cmd.fin_kind == FIN_FREE && !overflow) begin
        fc_r[cur_r] <= fc_cur + 16'd1;
      end
      if (cmd.fin) begin
        alloc_cnt_r <= alloc_nxt;
        fail_cnt_r  <= fail_nxt;
        fb_cnt_r    <= fb_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_granted        <= res_granted;
      out_pool_tag       <= res_tag;
      out_status         <= res_status;
      out_fell_back      <= res_fb;
      out_free_after     <= res_fa;
      out_low_mark       <= res_mf;
      out_alloc_total    <= alloc_nxt;
      out_fail_total     <= fail_nxt;
      out_fallback_total <= fb_nxt;
    end
  end

  `ASSERT_NEXT(a_grant_count, clk, rst_n, cmd.fin && cmd.fin_kind == FIN_GRANT,
               alloc_cnt_r == $past(alloc_cnt_r) + 32'd1)
  `ASSERT_IMPLIES(a_grant_after_best, clk, rst_n, cmd.fin && cmd.fin_kind == FIN_GRANT,
                  cur_r >= best_r)

endmodule

`default_nettype wire

// ===== design/multi_pool_best_fit_block_allocator.sv =====
// multi-pool best-fit block allocator
// keeps a free-block count and low-water mark for up to four pools and
// answers one result transfer for every request transfer on the in_ channel
// request: in_action 0 allocates a block for in_event_size bytes, 1 frees a
// block into the pool named by the one-based in_free_tag
// allocation picks the best-fitting pool, then walks the larger-index pools
// one per cycle until one holds more free blocks than its margin
// a no-fit or rejected free is decided in the fit check state; a free, a
// grant or a margin failure is decided in the scan state, at the pool the
// walk has reached; the result and out_valid are registered from there
// a request is taken only while idle, so each one is finished before the
// next is taken; a new request is taken while the previous result waits
// if the receiver stalls, the result holds in the output register and the
// block works the next request up to its result, then waits for out_ready
// reset clears the configuration, pool counts and totals and empties the
// output; writing the block count register reloads every free count and
// low-water mark
`default_nettype none

module multi_pool_best_fit_block_allocator #(
  parameter int POOL_COUNT = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // request channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_action,
  input  wire  [15:0]                  in_event_size,
  input  wire  [15:0]                  in_margin_override,
  input  wire  [2:0]                   in_free_tag,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_granted,
  output logic [2:0]                   out_pool_tag,
  output logic [2:0]                   out_status,
  output logic                         out_fell_back,
  output logic [15:0]                  out_free_after,
  output logic [15:0]                  out_low_mark,
  output logic [31:0]                  out_alloc_total,
  output logic [31:0]                  out_fail_total,
  output logic [31:0]                  out_fallback_total,
  // register port, 64-bit registers at 8-byte spacing
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [mpba_pkg::CFG_AW-1:0]  paddr,
  input  wire  [mpba_pkg::CFG_DW-1:0]  pwdata,
  output logic [mpba_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import mpba_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration registers and count reload pulse
  mpba_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: capture, best fit, pool scan, result transfer
  mpba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // pool counts, totals and the output register
  mpba_dp #(
    .POOL_COUNT (POOL_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_action),
    .in_event_size      (in_event_size),
    .in_margin_override (in_margin_override),
    .in_free_tag        (in_free_tag),
    .out_granted        (out_granted),
    .out_pool_tag       (out_pool_tag),
    .out_status         (out_status),
    .out_fell_back      (out_fell_back),
    .out_free_after     (out_free_after),
    .out_low_mark       (out_low_mark),
    .out_alloc_total    (out_alloc_total),
    .out_fail_total     (out_fail_total),
    .out_fallback_total (out_fallback_total)
  );

endmodule

`default_nettype wire
